[hw/rtl/fpfa_pkg.sv]
package fpfa_pkg;

    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    localparam int REQ_SIZE_W   = 16;
    localparam int LOAD_IDX_W   = 4;
    localparam int GRANT_IDX_W  = 4;
    localparam int BLK_COUNT_W  = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic MODE_FIRST_FIT = 1'b0;
    localparam logic MODE_BEST_FIT  = 1'b1;

    localparam logic [BLK_COUNT_W-1:0] BLK_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        logic start;
        logic take;
    } scan_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic granted;
    } scan_stat_t;

endpackage

[hw/rtl/fixed_partition_fit_allocator.sv]
// Load transaction: no result; the next transaction is taken the cycle after.
// Allocate transaction: the partitions in use are scanned, one entry read per cycle from
// the size memory into a single compare unit; the result is registered once the scan is
// done, later while a held result is stalled, and the next transaction is taken the
// cycle after the result is registered.
// Async active-low reset: all partitions free, first fit, sixteen in use; sizes unset.
module fixed_partition_fit_allocator #(
    parameter int NUM_BLOCKS = fpfa_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpfa_pkg::DEF_SIZE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [fpfa_pkg::LOAD_IDX_W-1:0]   load_index,
    input  logic [fpfa_pkg::REQ_SIZE_W-1:0]   load_size,
    input  logic [fpfa_pkg::REQ_SIZE_W-1:0]   request_size,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              granted,
    output logic [fpfa_pkg::GRANT_IDX_W-1:0]  granted_block
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int BCW   = (CNT_W > fpfa_pkg::BLK_COUNT_W) ? CNT_W : fpfa_pkg::BLK_COUNT_W;
    localparam int LIW   = (CNT_W > fpfa_pkg::LOAD_IDX_W) ? CNT_W : fpfa_pkg::LOAD_IDX_W;

    logic                             fit_mode_reg;
    logic [fpfa_pkg::BLK_COUNT_W-1:0] block_count_reg;
    logic                             out_valid_reg;
    logic                             granted_reg;
    logic [fpfa_pkg::GRANT_IDX_W-1:0] granted_block_reg;

    fpfa_pkg::scan_ctrl_t ctrl;
    fpfa_pkg::scan_stat_t stat;

    logic                 in_accept;
    logic [BCW-1:0]       bc_ext;
    logic [CNT_W-1:0]     count;
    logic                 wr_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_busy;
    logic [IDX_W-1:0]     pick;
    logic                 slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= fpfa_pkg::MODE_FIRST_FIT;
            block_count_reg <= fpfa_pkg::BLK_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpfa_pkg::REG_FIT_MODE:    fit_mode_reg    <= cfg_data[0];
                fpfa_pkg::REG_BLOCK_COUNT: block_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign bc_ext = BCW'(block_count_reg);
    assign count  = (bc_ext > BCW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bc_ext);

    assign in_stall  = !stat.idle;
    assign in_accept = in_valid && !in_stall;
    assign wr_en     = in_accept && (req_type == fpfa_pkg::REQ_LOAD)
                       && (LIW'(load_index) < LIW'(NUM_BLOCKS));

    assign slot_free  = !out_valid_reg || !out_stall;
    assign ctrl.start = in_accept && (req_type == fpfa_pkg::REQ_ALLOC);
    assign ctrl.take  = stat.done && slot_free;

    fpfa_store #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (IDX_W'(load_index)),
        .wr_size  (SIZE_BITS'(load_size)),
        .set_en   (ctrl.take && stat.granted),
        .set_addr (pick),
        .rd_addr  (rd_addr),
        .rd_size  (rd_size),
        .rd_busy  (rd_busy)
    );

    fpfa_scan #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .fit_mode (fit_mode_reg),
        .count    (count),
        .want     (request_size),
        .rd_size  (rd_size),
        .rd_busy  (rd_busy),
        .rd_addr  (rd_addr),
        .stat     (stat),
        .pick     (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            granted_reg       <= stat.granted;
            granted_block_reg <= fpfa_pkg::GRANT_IDX_W'(pick);
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign granted_block = granted_block_reg;

endmodule

[hw/rtl/fpfa_store.sv]
module fpfa_store #(
    parameter int NUM_BLOCKS = fpfa_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpfa_pkg::DEF_SIZE_BITS,
    parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [SIZE_BITS-1:0] wr_size,
    input  logic                 set_en,
    input  logic [IDX_W-1:0]     set_addr,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [SIZE_BITS-1:0] rd_size,
    output logic                 rd_busy
);

    logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] busy_reg;
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic                 rd_busy_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        rd_size_reg <= size_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= '0;
            rd_busy_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                busy_reg[wr_addr] <= 1'b0;
            end
            if (set_en)
            begin
                busy_reg[set_addr] <= 1'b1;
            end
            rd_busy_reg <= busy_reg[rd_addr];
        end
    end

    assign rd_size = rd_size_reg;
    assign rd_busy = rd_busy_reg;

endmodule

[hw/rtl/fpfa_scan.sv]
module fpfa_scan #(
    parameter int SIZE_BITS = fpfa_pkg::DEF_SIZE_BITS,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpfa_pkg::scan_ctrl_t            ctrl,
    input  logic                            fit_mode,
    input  logic [CNT_W-1:0]                count,
    input  logic [fpfa_pkg::REQ_SIZE_W-1:0] want,
    input  logic [SIZE_BITS-1:0]            rd_size,
    input  logic                            rd_busy,
    output logic [IDX_W-1:0]                rd_addr,
    output fpfa_pkg::scan_stat_t            stat,
    output logic [IDX_W-1:0]                pick
);

    localparam int CMP_W = (SIZE_BITS > fpfa_pkg::REQ_SIZE_W) ? SIZE_BITS
                                                                : fpfa_pkg::REQ_SIZE_W;

    fpfa_pkg::scan_state_t state_reg, state_next;

    logic [CNT_W-1:0]                addr_reg, addr_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [fpfa_pkg::REQ_SIZE_W-1:0] want_reg, want_next;
    logic                            mode_reg, mode_next;
    logic                            vld_reg, vld_next;
    logic [IDX_W-1:0]                cmp_idx_reg, cmp_idx_next;
    logic                            found_reg, found_next;
    logic [SIZE_BITS-1:0]            best_reg, best_next;
    logic [IDX_W-1:0]                pick_reg, pick_next;

    logic issue;
    logic fits;
    logic better;

    assign issue  = (state_reg == fpfa_pkg::ST_SCAN) && (addr_reg < count_reg);
    assign fits   = !rd_busy && (CMP_W'(rd_size) >= CMP_W'(want_reg));
    assign better = !found_reg
                    || ((mode_reg == fpfa_pkg::MODE_BEST_FIT) && (rd_size < best_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = fpfa_pkg::ST_SCAN;
                end
            end
            fpfa_pkg::ST_SCAN:
            begin
                if (!issue && !vld_reg)
                begin
                    state_next = fpfa_pkg::ST_DONE;
                end
            end
            fpfa_pkg::ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = fpfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        addr_next    = addr_reg;
        count_next   = count_reg;
        want_next    = want_reg;
        mode_next    = mode_reg;
        vld_next     = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    addr_next  = '0;
                    count_next = count;
                    want_next  = want;
                    mode_next  = fit_mode;
                    found_next = 1'b0;
                    pick_next  = '0;
                end
            end
            fpfa_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next    = addr_reg + 1'b1;
                    vld_next     = 1'b1;
                    cmp_idx_next = addr_reg[IDX_W-1:0];
                end
                if (vld_reg && fits && better)
                begin
                    found_next = 1'b1;
                    best_next  = rd_size;
                    pick_next  = cmp_idx_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpfa_pkg::ST_IDLE;
            addr_reg  <= '0;
            count_reg <= '0;
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
            pick_reg  <= '0;
            mode_reg  <= fpfa_pkg::MODE_FIRST_FIT;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            vld_reg   <= vld_next;
            found_reg <= found_next;
            pick_reg  <= pick_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg    <= want_next;
        cmp_idx_reg <= cmp_idx_next;
        best_reg    <= best_next;
    end

    assign rd_addr      = addr_reg[IDX_W-1:0];
    assign stat.idle    = (state_reg == fpfa_pkg::ST_IDLE);
    assign stat.done    = (state_reg == fpfa_pkg::ST_DONE);
    assign stat.granted = found_reg;
    assign pick         = found_reg ? pick_reg : '0;

endmodule

[sim/fixed_partition_fit_allocator_tb.sv]
module fixed_partition_fit_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    localparam int NUM_PART    = DEF_NUM_BLOCKS;
    localparam int SETTLE      = 30;
    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_ITEMS = 105;

    typedef struct {
        logic        req_type;
        logic [3:0]  load_index;
        logic [15:0] load_size;
        logic [15:0] request_size;
    } alloc_item_t;

    typedef struct {
        logic       granted;
        logic [3:0] blk;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = 1'b0;
    logic [LOAD_IDX_W-1:0]  load_index = '0;
    logic [REQ_SIZE_W-1:0]  load_size = '0;
    logic [REQ_SIZE_W-1:0]  request_size = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   granted;
    logic [GRANT_IDX_W-1:0] granted_block;

    alloc_item_t pending_q[$];
    grant_t      grant_expect_q[$];
    alloc_item_t cur_item = '{1'b0, 4'd0, 16'd0, 16'd0};

    // allocator state as predicted
    logic [15:0]            part_size_m [NUM_PART];
    bit                     part_busy_m [NUM_PART];
    logic                   fit_mode_m = MODE_FIRST_FIT;
    logic [BLK_COUNT_W-1:0] blk_count_m = BLK_COUNT_RESET;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_pct = 20;
    bit          no_idle = 1'b0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned n_loads = 0;
    int unsigned n_allocs = 0;
    int unsigned n_grants = 0;
    int unsigned n_settings = 0;

    fixed_partition_fit_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .load_index    (load_index),
        .load_size     (load_size),
        .request_size  (request_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .granted_block (granted_block)
    );

    always #6 clk = ~clk;

    function automatic void apply_request(input alloc_item_t it);
        grant_t      g;
        int unsigned lim;
        int unsigned j;
        int unsigned pick;
        bit          found;
        g = '{1'b0, 4'd0};
        if (it.req_type == REQ_LOAD) begin
            part_size_m[it.load_index] = it.load_size;
            part_busy_m[it.load_index] = 1'b0;
            n_loads++;
            return;
        end
        n_allocs++;
        lim = (blk_count_m > NUM_PART) ? NUM_PART : blk_count_m;
        found = 1'b0;
        pick = 0;
        for (j = 0; j < lim; j++) begin
            if (!part_busy_m[j] && part_size_m[j] >= it.request_size) begin
                if (!found) begin
                    found = 1'b1;
                    pick = j;
                    if (fit_mode_m == MODE_FIRST_FIT)
                        break;
                end else if (part_size_m[j] < part_size_m[pick]) begin
                    pick = j;
                end
            end
        end
        if (found) begin
            part_busy_m[pick] = 1'b1;
            g.granted = 1'b1;
            g.blk = pick[3:0];
            n_grants++;
        end
        grant_expect_q.push_back(g);
    endfunction

    function automatic logic [15:0] rand_size();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(8) * 1024);
            4: return 16'($urandom);
            default: return 16'($urandom_range(9000));
        endcase
    endfunction

    function automatic alloc_item_t rand_item(int unsigned alloc_pct);
        alloc_item_t it;
        it.req_type = ($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_LOAD;
        it.load_index = 4'($urandom_range(15));
        it.load_size = rand_size();
        it.request_size = rand_size();
        return it;
    endfunction

    task automatic push_load(input int unsigned idx, input logic [15:0] size);
        pending_q.push_back('{REQ_LOAD, idx[3:0], size, 16'($urandom)});
    endtask

    task automatic push_alloc(input logic [15:0] size);
        pending_q.push_back('{REQ_ALLOC, 4'($urandom_range(15)), 16'($urandom), size});
    endtask

    task automatic wait_quiet();
        while (pending_q.size() != 0 || in_valid || grant_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FIT_MODE)
            fit_mode_m = data[0];
        else
            blk_count_m = data;
    endtask

    task automatic set_mode_count(input logic mode, input logic [4:0] count);
        write_reg(REG_FIT_MODE, {4'd0, mode});
        write_reg(REG_BLOCK_COUNT, count);
        n_settings++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n) begin : drive_proc
        alloc_item_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid)
                apply_request(cur_item);
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_q.size() != 0 && !no_idle && $urandom_range(99) < idle_pct) begin
                gap_left <= $urandom_range(15);
                in_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                nxt = pending_q.pop_front();
                cur_item <= nxt;
                in_valid <= 1'b1;
                req_type <= nxt.req_type;
                load_index <= nxt.load_index;
                load_size <= nxt.load_size;
                request_size <= nxt.request_size;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n) begin : check_proc
        grant_t exp_g;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (grant_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction granted=%0b block=%0d",
                             $time, granted, granted_block);
                end else begin
                    exp_g = grant_expect_q.pop_front();
                    if (granted !== exp_g.granted) begin
                        errors++;
                        $display("%0t: granted expected %0b actual %0b",
                                 $time, exp_g.granted, granted);
                    end
                    if (granted_block !== exp_g.blk) begin
                        errors++;
                        $display("%0t: granted_block expected %0d actual %0d",
                                 $time, exp_g.blk, granted_block);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(99) < idle_pct) begin
                stall_left <= $urandom_range(15);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stim_proc
        logic [15:0] dir_sizes [NUM_PART];
        logic        mode_tab [7];
        logic [4:0]  count_tab [7];
        int unsigned p;
        int unsigned k;
        dir_sizes = '{16'd0, 16'hFFFF, 16'd300, 16'd100, 16'd300, 16'd50, 16'd200, 16'd100,
                      16'd7000, 16'd1, 16'd4096, 16'd4096, 16'd2, 16'd8000, 16'd900,
                      16'h8000};
        mode_tab = '{MODE_BEST_FIT, MODE_FIRST_FIT, MODE_BEST_FIT, MODE_FIRST_FIT,
                     MODE_BEST_FIT, MODE_BEST_FIT, MODE_FIRST_FIT};
        count_tab = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16};
        for (k = 0; k < NUM_PART; k++)
            part_busy_m[k] = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: every partition gets a size before any allocation
        set_mode_count(MODE_FIRST_FIT, 5'd16);
        for (k = 0; k < NUM_PART; k++)
            push_load(k, dir_sizes[k]);
        push_alloc(16'd0);
        push_alloc(16'hFFFF);
        push_alloc(16'hFFFF);
        push_alloc(16'd150);
        push_load(1, 16'hFFFF);     // reload of a busy partition frees it
        push_alloc(16'hFFFF);
        wait_quiet();
        set_mode_count(MODE_BEST_FIT, 5'd16);
        push_alloc(16'd100);
        push_alloc(16'd100);
        push_alloc(16'd0);
        push_alloc(16'd5000);
        wait_quiet();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p < 7)
                set_mode_count(mode_tab[p], count_tab[p]);
            else
                set_mode_count(1'($urandom_range(1)), 5'($urandom_range(31)));
            idle_pct = (p == 3 || p == 6) ? 0 : 20;
            no_idle = (p == NUM_PHASES - 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pending_q.push_back(rand_item(55));
                // stimulus stops queueing until the block has drained
                if (p == 4 && k == PHASE_ITEMS / 2)
                    wait_quiet();
            end
            wait_quiet();
        end

        $display("covered %0d loads and %0d allocations (%0d granted, %0d refused)",
                 n_loads, n_allocs, n_grants, n_allocs - n_grants);
        $display("over %0d register settings, both fit modes, block counts 0 to 31",
                 n_settings);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
